>>> hdl/ebd_pkg.sv
package ebd_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_ESC       = 4'd1,
        PH_OCT       = 4'd2,
        PH_HEX1      = 4'd3,
        PH_HEX2      = 4'd4,
        PH_META_DASH = 4'd5,
        PH_META_CHAR = 4'd6,
        PH_CTRL_DASH = 4'd7,
        PH_CTRL_CHAR = 4'd8
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_NO_BSL    = 4'd1,
        ST_SHORT_ESC = 4'd2,
        ST_BAD_HEX   = 4'd3,
        ST_DUP_META  = 4'd4,
        ST_SHORT_MET = 4'd5,
        ST_SHORT_CTL = 4'd6,
        ST_DUP_CTRL  = 4'd7,
        ST_UNEXPECT  = 4'd8,
        ST_RANGE     = 4'd9
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_result;

    localparam logic [7:0] CH_BSL  = 8'h5c;
    localparam logic [7:0] CH_DASH = 8'h2d;
    localparam logic [7:0] META_BIT  = 8'h80;
    localparam logic [7:0] CTRL_MASK = 8'h1f;
    localparam logic [8:0] CODE_MAX  = 9'h0ff;

endpackage

>>> hdl/escaped_byte_decoder_core.sv
// channel | valid      | stall       | payload
// in      | i_in_valid | o_in_stall  | i_in_byte, i_buffer_end
// out     | o_out_valid| i_out_stall | o_decoded_byte, o_status, o_run_last
//
// One input beat per cycle while o_in_stall is low; each beat is decoded in the cycle it is accepted
// and gives zero, one or two results, pushed into a four-entry result queue.
// Input is taken while the queue has room for two results.
// Reset (synchronous, active low) empties the queue and returns to idle.
module escaped_byte_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_buffer_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_decoded_byte,
    output logic [3:0] o_status,
    output logic       o_run_last
);

    ebd_pkg::t_phase r_phase, n_phase;
    logic       r_meta, n_meta;
    logic       r_ctrl, n_ctrl;
    logic [8:0] r_acc, n_acc;
    logic [1:0] r_cnt, n_cnt;

    ebd_pkg::t_result r_q [4];
    logic [1:0] r_wr_ptr, r_rd_ptr;
    logic [2:0] r_count;

    ebd_pkg::t_result res0, res1;
    logic [1:0] res_n;

    logic       accept, pop;
    logic [7:0] b;
    logic       e;
    logic       is_bsl, is_oct, is_hex;
    logic [3:0] hex_v;
    logic [8:0] oct_acc;
    logic [1:0] oct_cnt;
    logic       oct_done;
    logic [8:0] hex_code;

    function automatic ebd_pkg::t_result fin(input logic [8:0] code, input logic meta,
                                             input logic ctrl);
        ebd_pkg::t_result r;
        logic [7:0] c;
        c = code[7:0];
        if (ctrl) c = c & ebd_pkg::CTRL_MASK;
        if (meta) c = c | ebd_pkg::META_BIT;
        r.data   = c;
        r.status = ebd_pkg::ST_OK;
        r.last   = 1'b0;
        if (code > ebd_pkg::CODE_MAX) begin
            r.data   = 8'h00;
            r.status = ebd_pkg::ST_RANGE;
        end
        return r;
    endfunction

    function automatic ebd_pkg::t_result fail(input ebd_pkg::t_status st);
        ebd_pkg::t_result r;
        r.data   = 8'h00;
        r.status = st;
        r.last   = 1'b0;
        return r;
    endfunction

    assign b      = i_in_byte;
    assign e      = i_buffer_end;
    assign is_bsl = (b == ebd_pkg::CH_BSL);
    assign is_oct = b inside {[8'h30:8'h37]};

    always_comb begin
        is_hex = 1'b1;
        hex_v  = 4'h0;
        if (b inside {[8'h30:8'h39]}) begin
            hex_v = b[3:0];
        end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            hex_v = b[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    assign oct_acc  = {r_acc[5:0], b[2:0]};
    assign oct_cnt  = r_cnt + 2'd1;
    assign oct_done = (oct_cnt == 2'd3) || e;
    assign hex_code = {1'b0, r_acc[3:0], hex_v};

    assign o_in_stall = (r_count > 3'd2);
    assign accept     = i_in_valid && !o_in_stall;
    assign pop        = o_out_valid && !i_out_stall;

    // results of the current beat
    always_comb begin
        res0  = fail(ebd_pkg::ST_OK);
        res1  = fail(ebd_pkg::ST_OK);
        res_n = 2'd0;
        case (r_phase)
            ebd_pkg::PH_ESC: begin
                res_n = 2'd1;
                case (b)
                    8'h5c: res0 = fin(9'h05c, r_meta, r_ctrl);
                    8'h6e: res0 = fin(9'h00a, r_meta, r_ctrl);
                    8'h74: res0 = fin(9'h009, r_meta, r_ctrl);
                    8'h72: res0 = fin(9'h00d, r_meta, r_ctrl);
                    8'h66: res0 = fin(9'h00c, r_meta, r_ctrl);
                    8'h76: res0 = fin(9'h00b, r_meta, r_ctrl);
                    8'h61: res0 = fin(9'h007, r_meta, r_ctrl);
                    8'h65: res0 = fin(9'h01b, r_meta, r_ctrl);
                    8'h78: begin
                        res0  = fail(ebd_pkg::ST_BAD_HEX);
                        res_n = e ? 2'd1 : 2'd0;
                    end
                    8'h4d: begin
                        if (r_meta) begin
                            res0 = fail(ebd_pkg::ST_DUP_META);
                        end else begin
                            res0  = fail(ebd_pkg::ST_SHORT_MET);
                            res_n = e ? 2'd1 : 2'd0;
                        end
                    end
                    8'h43: begin
                        res0  = fail(ebd_pkg::ST_SHORT_CTL);
                        res_n = e ? 2'd1 : 2'd0;
                    end
                    8'h63: begin
                        if (r_ctrl) begin
                            res0 = fail(ebd_pkg::ST_DUP_CTRL);
                        end else begin
                            res0  = fail(ebd_pkg::ST_SHORT_CTL);
                            res_n = e ? 2'd1 : 2'd0;
                        end
                    end
                    default: begin
                        if (is_oct) begin
                            res0  = fin({6'd0, b[2:0]}, r_meta, r_ctrl);
                            res_n = e ? 2'd1 : 2'd0;
                        end else begin
                            res0 = fail(ebd_pkg::ST_UNEXPECT);
                        end
                    end
                endcase
            end
            ebd_pkg::PH_OCT, ebd_pkg::PH_HEX2: begin
                if (r_phase == ebd_pkg::PH_OCT && is_oct) begin
                    res0  = fin(oct_acc, r_meta, r_ctrl);
                    res_n = oct_done ? 2'd1 : 2'd0;
                end else if (r_phase == ebd_pkg::PH_HEX2 && is_hex) begin
                    res0  = fin(hex_code, r_meta, r_ctrl);
                    res_n = 2'd1;
                end else begin
                    // run ends; this byte should start the next escape, else ST_NO_BSL follows
                    res0  = fin(r_acc, r_meta, r_ctrl);
                    res_n = 2'd1;
                    if (!is_bsl) begin
                        res1  = fail(ebd_pkg::ST_NO_BSL);
                        res_n = 2'd2;
                    end else if (e) begin
                        res1  = fail(ebd_pkg::ST_SHORT_ESC);
                        res_n = 2'd2;
                    end
                end
            end
            ebd_pkg::PH_HEX1: begin
                if (!is_hex) begin
                    res0  = fail(ebd_pkg::ST_BAD_HEX);
                    res_n = 2'd1;
                end else if (e) begin
                    res0  = fin({5'd0, hex_v}, r_meta, r_ctrl);
                    res_n = 2'd1;
                end
            end
            ebd_pkg::PH_META_DASH: begin
                if (b != ebd_pkg::CH_DASH || e) begin
                    res0  = fail(ebd_pkg::ST_SHORT_MET);
                    res_n = 2'd1;
                end
            end
            ebd_pkg::PH_CTRL_DASH: begin
                res_n = 2'd1;
                if (b != ebd_pkg::CH_DASH) begin
                    res0 = fail(ebd_pkg::ST_SHORT_CTL);
                end else if (r_ctrl) begin
                    res0 = fail(ebd_pkg::ST_DUP_CTRL);
                end else if (e) begin
                    res0 = fail(ebd_pkg::ST_SHORT_CTL);
                end else begin
                    res_n = 2'd0;
                end
            end
            ebd_pkg::PH_META_CHAR, ebd_pkg::PH_CTRL_CHAR: begin
                res_n = 2'd1;
                if (b[7]) begin
                    res0 = fail((r_phase == ebd_pkg::PH_META_CHAR) ?
                                ebd_pkg::ST_SHORT_MET : ebd_pkg::ST_SHORT_CTL);
                end else if (is_bsl) begin
                    res0  = fail(ebd_pkg::ST_SHORT_ESC);
                    res_n = e ? 2'd1 : 2'd0;
                end else begin
                    res0 = fin({1'b0, b}, r_meta, r_ctrl);
                end
            end
            default: begin
                if (!is_bsl) begin
                    res0  = fail(ebd_pkg::ST_NO_BSL);
                    res_n = 2'd1;
                end else if (e) begin
                    res0  = fail(ebd_pkg::ST_SHORT_ESC);
                    res_n = 2'd1;
                end
            end
        endcase
        if (res_n == 2'd1) res0.last = 1'b1;
        res1.last = 1'b1;
    end

    // next decoder state
    always_comb begin
        n_phase = ebd_pkg::PH_IDLE;
        n_meta  = 1'b0;
        n_ctrl  = 1'b0;
        n_acc   = 9'd0;
        n_cnt   = 2'd0;
        case (r_phase)
            ebd_pkg::PH_ESC: begin
                case (b)
                    8'h78: begin
                        if (!e) begin
                            n_phase = ebd_pkg::PH_HEX1;
                            n_meta  = r_meta;
                            n_ctrl  = r_ctrl;
                        end
                    end
                    8'h4d: begin
                        if (!r_meta && !e) begin
                            n_phase = ebd_pkg::PH_META_DASH;
                            n_meta  = 1'b1;
                            n_ctrl  = r_ctrl;
                        end
                    end
                    8'h43: begin
                        if (!e) begin
                            n_phase = ebd_pkg::PH_CTRL_DASH;
                            n_meta  = r_meta;
                            n_ctrl  = r_ctrl;
                        end
                    end
                    8'h63: begin
                        if (!r_ctrl && !e) begin
                            n_phase = ebd_pkg::PH_CTRL_CHAR;
                            n_meta  = r_meta;
                            n_ctrl  = 1'b1;
                        end
                    end
                    default: begin
                        if (is_oct && !e) begin
                            n_phase = ebd_pkg::PH_OCT;
                            n_meta  = r_meta;
                            n_ctrl  = r_ctrl;
                            n_acc   = {6'd0, b[2:0]};
                            n_cnt   = 2'd1;
                        end
                    end
                endcase
            end
            ebd_pkg::PH_OCT, ebd_pkg::PH_HEX2: begin
                if (r_phase == ebd_pkg::PH_OCT && is_oct) begin
                    if (!oct_done) begin
                        n_phase = ebd_pkg::PH_OCT;
                        n_meta  = r_meta;
                        n_ctrl  = r_ctrl;
                        n_acc   = oct_acc;
                        n_cnt   = oct_cnt;
                    end
                end else if (!(r_phase == ebd_pkg::PH_HEX2 && is_hex)) begin
                    if (is_bsl && !e) n_phase = ebd_pkg::PH_ESC;
                end
            end
            ebd_pkg::PH_HEX1: begin
                if (is_hex && !e) begin
                    n_phase = ebd_pkg::PH_HEX2;
                    n_meta  = r_meta;
                    n_ctrl  = r_ctrl;
                    n_acc   = {5'd0, hex_v};
                    n_cnt   = 2'd1;
                end
            end
            ebd_pkg::PH_META_DASH: begin
                if (b == ebd_pkg::CH_DASH && !e) begin
                    n_phase = ebd_pkg::PH_META_CHAR;
                    n_meta  = r_meta;
                    n_ctrl  = r_ctrl;
                end
            end
            ebd_pkg::PH_CTRL_DASH: begin
                if (b == ebd_pkg::CH_DASH && !r_ctrl && !e) begin
                    n_phase = ebd_pkg::PH_CTRL_CHAR;
                    n_meta  = r_meta;
                    n_ctrl  = 1'b1;
                end
            end
            ebd_pkg::PH_META_CHAR, ebd_pkg::PH_CTRL_CHAR: begin
                if (!b[7] && is_bsl && !e) begin
                    n_phase = ebd_pkg::PH_ESC;
                    n_meta  = r_meta;
                    n_ctrl  = r_ctrl;
                end
            end
            default: begin
                if (is_bsl && !e) n_phase = ebd_pkg::PH_ESC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ebd_pkg::PH_IDLE;
            r_meta  <= 1'b0;
            r_ctrl  <= 1'b0;
            r_acc   <= 9'd0;
            r_cnt   <= 2'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_meta  <= n_meta;
            r_ctrl  <= n_ctrl;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (accept && res_n != 2'd0) r_q[r_wr_ptr] <= res0;
        if (accept && res_n == 2'd2) r_q[r_wr_ptr + 2'd1] <= res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (accept) r_wr_ptr <= r_wr_ptr + res_n;
            if (pop) r_rd_ptr <= r_rd_ptr + 2'd1;
            r_count <= r_count + (accept ? {1'b0, res_n} : 3'd0) - {2'd0, pop};
        end
    end

    assign o_out_valid    = (r_count != 3'd0);
    assign o_decoded_byte = r_q[r_rd_ptr].data;
    assign o_status       = r_q[r_rd_ptr].status;
    assign o_run_last     = r_q[r_rd_ptr].last;

endmodule

>>> tb/tb.sv
module tb;

    localparam int RAND_BEATS = 1820;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } t_raw_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       i_buffer_end;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_decoded_byte;
    logic [3:0] o_status;
    logic       o_run_last;

    t_raw_beat          raw_q[$];
    ebd_pkg::t_result   decoded_q[$];
    int         n_errors = 0;
    int         beats_done = 0;
    int         total_beats = 0;
    logic       beat_taken = 1'b0;

    // decoder state kept by the predictor
    ebd_pkg::t_phase dec_phase;
    logic       meta_on;
    logic       ctrl_on;
    logic [8:0] dig_acc;
    logic [1:0] dig_cnt;

    escaped_byte_decoder_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .i_buffer_end   (i_buffer_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_decoded_byte (o_decoded_byte),
        .o_status       (o_status),
        .o_run_last     (o_run_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("** escaped_byte_decoder_core: FAILED **");
        $finish;
    end

    task report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        n_errors++;
    endtask

    function automatic void clear_decoder();
        dec_phase = ebd_pkg::PH_IDLE;
        meta_on   = 1'b0;
        ctrl_on   = 1'b0;
        dig_acc   = '0;
        dig_cnt   = '0;
    endfunction

    function automatic void emit(logic [7:0] code, ebd_pkg::t_status st);
        ebd_pkg::t_result r;
        r.data   = code;
        r.status = st;
        r.last   = 1'b0;
        decoded_q.push_back(r);
    endfunction

    function automatic void fail_escape(ebd_pkg::t_status st);
        clear_decoder();
        emit(8'h00, st);
    endfunction

    function automatic void finish_code(logic [8:0] code);
        logic [7:0] v;
        if (code > ebd_pkg::CODE_MAX) begin
            fail_escape(ebd_pkg::ST_RANGE);
            return;
        end
        v = code[7:0];
        if (ctrl_on) v &= ebd_pkg::CTRL_MASK;
        if (meta_on) v |= ebd_pkg::META_BIT;
        clear_decoder();
        emit(v, ebd_pkg::ST_OK);
    endfunction

    function automatic int hex_value(logic [7:0] b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    function automatic void start_escape(logic [7:0] b, logic fin);
        if (b != ebd_pkg::CH_BSL) fail_escape(ebd_pkg::ST_NO_BSL);
        else if (fin) fail_escape(ebd_pkg::ST_SHORT_ESC);
        else dec_phase = ebd_pkg::PH_ESC;
    endfunction

    function automatic void after_prefix(logic [7:0] b, logic fin,
                                         ebd_pkg::t_status short_st);
        if (b[7]) begin
            fail_escape(short_st);
        end else if (b == ebd_pkg::CH_BSL) begin
            if (fin) fail_escape(ebd_pkg::ST_SHORT_ESC);
            else dec_phase = ebd_pkg::PH_ESC;
        end else begin
            finish_code({1'b0, b});
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic fin);
        int base;
        int h;
        base = decoded_q.size();
        h = hex_value(b);
        case (dec_phase)
            ebd_pkg::PH_IDLE: start_escape(b, fin);
            ebd_pkg::PH_ESC: begin
                case (b)
                    ebd_pkg::CH_BSL: finish_code(9'h05c);
                    "n": finish_code(9'h00a);
                    "t": finish_code(9'h009);
                    "r": finish_code(9'h00d);
                    "f": finish_code(9'h00c);
                    "v": finish_code(9'h00b);
                    "a": finish_code(9'h007);
                    "e": finish_code(9'h01b);
                    "x": begin
                        if (fin) fail_escape(ebd_pkg::ST_BAD_HEX);
                        else dec_phase = ebd_pkg::PH_HEX1;
                    end
                    "M": begin
                        if (meta_on) begin
                            fail_escape(ebd_pkg::ST_DUP_META);
                        end else begin
                            meta_on = 1'b1;
                            if (fin) fail_escape(ebd_pkg::ST_SHORT_MET);
                            else dec_phase = ebd_pkg::PH_META_DASH;
                        end
                    end
                    "C": begin
                        if (fin) fail_escape(ebd_pkg::ST_SHORT_CTL);
                        else dec_phase = ebd_pkg::PH_CTRL_DASH;
                    end
                    "c": begin
                        if (ctrl_on) begin
                            fail_escape(ebd_pkg::ST_DUP_CTRL);
                        end else begin
                            ctrl_on = 1'b1;
                            if (fin) fail_escape(ebd_pkg::ST_SHORT_CTL);
                            else dec_phase = ebd_pkg::PH_CTRL_CHAR;
                        end
                    end
                    default: begin
                        if (b >= "0" && b <= "7") begin
                            dig_acc = {6'd0, b[2:0]};
                            dig_cnt = 2'd1;
                            if (fin) finish_code(dig_acc);
                            else dec_phase = ebd_pkg::PH_OCT;
                        end else begin
                            fail_escape(ebd_pkg::ST_UNEXPECT);
                        end
                    end
                endcase
            end
            ebd_pkg::PH_OCT: begin
                if (b >= "0" && b <= "7") begin
                    dig_acc = {dig_acc[5:0], b[2:0]};
                    dig_cnt = dig_cnt + 2'd1;
                    if (dig_cnt == 2'd3 || fin) finish_code(dig_acc);
                end else begin
                    finish_code(dig_acc);
                    start_escape(b, fin);
                end
            end
            ebd_pkg::PH_HEX1: begin
                if (h < 0) begin
                    fail_escape(ebd_pkg::ST_BAD_HEX);
                end else begin
                    dig_acc = 9'(h);
                    dig_cnt = 2'd1;
                    if (fin) finish_code(dig_acc);
                    else dec_phase = ebd_pkg::PH_HEX2;
                end
            end
            ebd_pkg::PH_HEX2: begin
                if (h >= 0) begin
                    finish_code({1'b0, dig_acc[3:0], 4'(h)});
                end else begin
                    finish_code(dig_acc);
                    start_escape(b, fin);
                end
            end
            ebd_pkg::PH_META_DASH: begin
                if (b != ebd_pkg::CH_DASH || fin) fail_escape(ebd_pkg::ST_SHORT_MET);
                else dec_phase = ebd_pkg::PH_META_CHAR;
            end
            ebd_pkg::PH_META_CHAR: after_prefix(b, fin, ebd_pkg::ST_SHORT_MET);
            ebd_pkg::PH_CTRL_DASH: begin
                if (b != ebd_pkg::CH_DASH) begin
                    fail_escape(ebd_pkg::ST_SHORT_CTL);
                end else if (ctrl_on) begin
                    fail_escape(ebd_pkg::ST_DUP_CTRL);
                end else begin
                    ctrl_on = 1'b1;
                    if (fin) fail_escape(ebd_pkg::ST_SHORT_CTL);
                    else dec_phase = ebd_pkg::PH_CTRL_CHAR;
                end
            end
            ebd_pkg::PH_CTRL_CHAR: after_prefix(b, fin, ebd_pkg::ST_SHORT_CTL);
            default: begin
                clear_decoder();
                start_escape(b, fin);
            end
        endcase
        if (decoded_q.size() > base) decoded_q[decoded_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void queue_beat(logic [7:0] b, logic fin);
        t_raw_beat rb;
        rb.data = b;
        rb.fin  = fin;
        raw_q.push_back(rb);
    endfunction

    function automatic void queue_text(string s, logic fin_last);
        for (int i = 0; i < s.len(); i++) queue_beat(s[i], fin_last && i == s.len() - 1);
    endfunction

    // driver: new beat only once the previous one is taken
    always @(negedge i_clk) begin : driver
        int send_pct;
        int recv_pct;
        if (beats_done * 3 < total_beats) begin
            send_pct = 26;
            recv_pct = 83;
        end else if (beats_done * 3 < 2 * total_beats) begin
            send_pct = 83;
            recv_pct = 26;
        end else begin
            send_pct = 0;
            recv_pct = 0;
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || beat_taken) begin
            if (raw_q.size() > 0 && $urandom_range(0, 99) >= send_pct) begin
                i_in_valid   <= 1'b1;
                i_in_byte    <= raw_q[0].data;
                i_buffer_end <= raw_q[0].fin;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_pct);
    end

    always @(posedge i_clk) begin : monitor
        ebd_pkg::t_result want;
        beat_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_in_byte, i_buffer_end);
                raw_q.delete(0);
                beats_done++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result byte %02h status %0d",
                                              o_decoded_byte, o_status));
                end else begin
                    want = decoded_q.pop_front();
                    if (o_decoded_byte !== want.data)
                        report_mismatch($sformatf("decoded_byte %02h, want %02h",
                                                  o_decoded_byte, want.data));
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  o_status, want.status));
                    if (o_run_last !== want.last)
                        report_mismatch($sformatf("run_last %0b, want %0b",
                                                  o_run_last, want.last));
                end
            end
        end
    end

    initial begin : stimulus
        logic [7:0] seq[$];
        string      letters;
        string      hexd;
        int         pick;
        int         n_pre;
        int         n;
        int         end_at;
        int         r;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_byte    = 8'h00;
        i_buffer_end = 1'b0;
        i_out_stall  = 1'b0;
        clear_decoder();
        letters = "\\ntrfvae";
        hexd    = "0123456789abcdefABCDEF";

        queue_beat(8'hff, 1'b1);
        queue_text("\\", 1'b1);
        queue_text("\\xF\\", 1'b1);
        queue_text("\\777", 1'b0);
        queue_text("\\M-", 1'b0);
        queue_beat(8'h80, 1'b1);
        queue_text("\\C-\\c", 1'b1);
        queue_text("\\M-\\M", 1'b1);

        total_beats = raw_q.size() + RAND_BEATS;
        while (raw_q.size() < total_beats) begin
            seq.delete();
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                seq.push_back(8'($urandom_range(0, 255)));
            end else begin
                seq.push_back(ebd_pkg::CH_BSL);
                n_pre = (pick < 10) ? 0 : $urandom_range(1, 3);
                for (int k = 0; k < n_pre; k++) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            seq.push_back("M");
                            seq.push_back(ebd_pkg::CH_DASH);
                        end
                        1: begin
                            seq.push_back("C");
                            seq.push_back(ebd_pkg::CH_DASH);
                        end
                        default: seq.push_back("c");
                    endcase
                    if (k < n_pre - 1) seq.push_back(ebd_pkg::CH_BSL);
                end
                if (n_pre > 0 && $urandom_range(0, 2) != 0) begin
                    if ($urandom_range(0, 7) == 0) seq.push_back(8'($urandom_range(0, 255)));
                    else seq.push_back(8'($urandom_range(0, 127)));
                end else begin
                    if (n_pre > 0) seq.push_back(ebd_pkg::CH_BSL);
                    case ($urandom_range(0, 7))
                        0, 1: seq.push_back(letters[$urandom_range(0, 7)]);
                        2, 3: begin
                            n = $urandom_range(1, 3);
                            for (int i = 0; i < n; i++)
                                seq.push_back(8'("0" + $urandom_range(0, 7)));
                        end
                        4, 5: begin
                            seq.push_back("x");
                            n = $urandom_range(1, 2);
                            for (int i = 0; i < n; i++)
                                seq.push_back(hexd[$urandom_range(0, 21)]);
                        end
                        6: seq.push_back(8'($urandom_range(0, 255)));
                        default: begin
                            seq.push_back("x");
                            seq.push_back(8'($urandom_range(0, 255)));
                        end
                    endcase
                end
            end
            r = $urandom_range(0, 9);
            if (r < 3) end_at = seq.size() - 1;
            else if (r == 3) end_at = $urandom_range(0, seq.size() - 1);
            else end_at = -1;
            for (int i = 0; i < seq.size(); i++) queue_beat(seq[i], i == end_at);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (raw_q.size() != 0 || decoded_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("** escaped_byte_decoder_core: PASSED **");
        end else begin
            $display("** escaped_byte_decoder_core: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/ebd_pkg.sv
hdl/escaped_byte_decoder_core.sv
tb/tb.sv
